FILE: design/nscc_pkg.sv
// Package for the NMEA sentence checksum checker.
// Holds the operation codes, character constants, state record and hex decode.
// No dependencies.
`default_nettype none

package nscc_pkg;

   // Operation codes carried on the request opcode field
   typedef enum logic [0:0] {
      OP_OBSERVE = 1'b0,
      OP_CLEAR   = 1'b1
   } nscc_op_type;

   // Characters of interest
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] PRINT_LO  = 8'd32;
   localparam logic [7:0] PRINT_HI  = 8'd126;

   // Two hex digits close the checksum field
   localparam logic [1:0] HEX_DIGITS = 2'd2;

   // Sentence tracking state
   typedef struct packed {
      logic       in_sentence;
      logic       in_checksum_field;
      logic       talker_is_g;
      logic       valid_flag;
      logic [7:0] running_xor;
      logic [7:0] expected_sum;
      logic [1:0] hex_digit_count;
      logic [7:0] payload_count;
   } nscc_state_type;

   // Hex digit decode: bit 4 set means the byte is not a hex digit
   function automatic logic [4:0] nibble_of(input logic [7:0] b);
      logic [4:0] n;
      if (b >= 8'h30 && b <= 8'h39) begin
         n = {1'b0, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         n = {1'b0, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         n = {1'b0, 4'(b - 8'h57)};
      end else begin
         n = 5'h10;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: design/nscc_step.sv
// Next-state logic for one received byte of the NMEA checksum checker.
// Depends on nscc_pkg for codes, constants and the state record.
`default_nettype none

module nscc_step
   import nscc_pkg::*;
(
   input  wire nscc_state_type cur_state,
   input  wire nscc_op_type    opcode,
   input  wire logic [7:0]     rx_byte,
   output nscc_state_type      nxt_state
);

   logic [4:0] nib;
   logic [7:0] sum_shifted;
   logic       printable;

   assign nib         = nibble_of(rx_byte);
   assign sum_shifted = {cur_state.expected_sum[3:0], nib[3:0]};
   assign printable   = (rx_byte >= PRINT_LO) && (rx_byte <= PRINT_HI);

   // Advance the sentence state for one byte or a clear
   always_comb begin
      nxt_state = cur_state;
      if (opcode == OP_CLEAR) begin
         nxt_state = '0;
      end else if (rx_byte == CH_DOLLAR) begin
         // Restart the sentence, keep the valid flag
         nxt_state             = '0;
         nxt_state.in_sentence = 1'b1;
         nxt_state.valid_flag  = cur_state.valid_flag;
      end else if (!cur_state.in_sentence) begin
         nxt_state = cur_state;
      end else if (!cur_state.in_checksum_field) begin
         if (rx_byte == CH_STAR) begin
            nxt_state.in_checksum_field = 1'b1;
         end else if (!printable) begin
            nxt_state.in_sentence = 1'b0;
         end else begin
            if (cur_state.payload_count == 8'd0) begin
               nxt_state.talker_is_g = (rx_byte == CH_G);
            end
            nxt_state.payload_count = cur_state.payload_count + 8'd1;
            nxt_state.running_xor   = cur_state.running_xor ^ rx_byte;
         end
      end else begin
         if (nib[4] || (cur_state.hex_digit_count >= HEX_DIGITS)) begin
            nxt_state.in_sentence = 1'b0;
         end else begin
            nxt_state.expected_sum    = sum_shifted;
            nxt_state.hex_digit_count = cur_state.hex_digit_count + 2'd1;
            // Second digit closes the sentence and sets the flag
            if (cur_state.hex_digit_count + 2'd1 == HEX_DIGITS) begin
               nxt_state.valid_flag  = cur_state.talker_is_g &&
                                       (cur_state.running_xor == sum_shifted);
               nxt_state.in_sentence = 1'b0;
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/nmea_sentence_checksum_checker.sv
// NMEA sentence checksum checker, top level.
// The result is registered and shows on rsp_valid in the cycle after the request transfer.
// Throughput: one byte per cycle while req_stall is low; the single state update sets the rate.
// Requests stall only while a result is held and the result side stalls.
// Synchronous active-high reset clears all sentence state and the result.
// Depends on nscc_pkg and nscc_step.
`default_nettype none

module nmea_sentence_checksum_checker
   import nscc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [0:0] req_opcode,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [0:0]      rsp_valid_seen
);

   nscc_state_type state_ff;
   nscc_state_type state_in;
   nscc_state_type step_state;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           rsp_seen_ff;
   logic           rsp_seen_in;
   logic           req_take;

   // Hold requests only while a result is waiting and not taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   nscc_step u_step (
      .cur_state (state_ff),
      .opcode    (nscc_op_type'(req_opcode)),
      .rx_byte   (req_rx_byte),
      .nxt_state (step_state)
   );

   // Update state on each request transfer and load the result register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_seen_in  = rsp_seen_ff;
      if (req_take) begin
         state_in     = step_state;
         rsp_valid_in = 1'b1;
         rsp_seen_in  = step_state.valid_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_seen_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_seen_ff  <= rsp_seen_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_valid_seen = rsp_seen_ff;

endmodule

`default_nettype wire
